@@ src/dmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg: shared types and constants of the maze carver
// Command, status and direction codes, register indexes and the packed
// words that travel on the command and result ports.
// ----------------------------------------------------------------------------
package dmc_pkg;

	localparam int MAX_DIM_DEF = 64;
	localparam int GRID_REG_W  = 7;
	localparam int DIM_RESET   = 64;
	localparam int COORD_W     = 6;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_STARTED     = 3'd0,
		ST_CARVED      = 3'd1,
		ST_BACKTRACKED = 3'd2,
		ST_RETRY       = 3'd3,
		ST_DONE        = 3'd4,
		ST_READ        = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		DIR_WEST  = 2'd0,
		DIR_EAST  = 2'd1,
		DIR_NORTH = 2'd2,
		DIR_SOUTH = 2'd3
	} dir_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [1:0]           random_draw;
		logic [COORD_W-1:0]   read_col;
		logic [COORD_W-1:0]   read_row;
	} in_t;

	typedef struct packed {
		status_t              status;
		logic [COORD_W-1:0]   cell_col;
		logic [COORD_W-1:0]   cell_row;
		logic [COORD_W-1:0]   wall_col;
		logic [COORD_W-1:0]   wall_row;
		logic                 cell_open;
	} out_t;

endpackage

@@ src/dmc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dmc_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 1,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/dmc_nbr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_nbr: neighbor address unit
// For one direction, forms the cell two away and the wall cell between,
// and checks that the target lies on the grid. Shared by all four probes.
// ----------------------------------------------------------------------------
module dmc_nbr #(
	parameter int CW = 6
) (
	input  logic [CW-1:0]  cur_col,
	input  logic [CW-1:0]  cur_row,
	input  dmc_pkg::dir_t  dir,
	input  logic [CW:0]    dim_w,
	input  logic [CW:0]    dim_h,
	output logic [CW-1:0]  tgt_col,
	output logic [CW-1:0]  tgt_row,
	output logic [CW-1:0]  wall_col,
	output logic [CW-1:0]  wall_row,
	output logic           inb
);

	logic          vert;
	logic          neg;
	logic [CW:0]   coord;
	logic [CW:0]   lim;
	logic [CW:0]   sum;
	logic [CW:0]   mid;

	always_comb begin
		vert  = (dir == dmc_pkg::DIR_NORTH) || (dir == dmc_pkg::DIR_SOUTH);
		neg   = (dir == dmc_pkg::DIR_WEST) || (dir == dmc_pkg::DIR_NORTH);
		coord = {1'b0, (vert ? cur_row : cur_col)};
		lim   = vert ? dim_h : dim_w;
		sum   = neg ? (coord - (CW+1)'(2)) : (coord + (CW+1)'(2));
		mid   = neg ? (coord - (CW+1)'(1)) : (coord + (CW+1)'(1));
		// Moving toward zero needs the coordinate to be at least two; moving away needs the target inside the grid.
		inb   = neg ? (coord >= (CW+1)'(2)) : (sum < lim);
		tgt_col  = vert ? cur_col : sum[CW-1:0];
		tgt_row  = vert ? sum[CW-1:0] : cur_row;
		wall_col = vert ? cur_col : mid[CW-1:0];
		wall_row = vert ? mid[CW-1:0] : cur_row;
	end

endmodule

@@ src/dfs_maze_carver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_maze_carver: randomized depth-first maze carver
// Recursive backtracker over a one-bit open/wall map with an explicit stack.
// A small sequencer probes the four neighbors through one address unit and
// one map read port, then carves, backtracks or reports.
// ----------------------------------------------------------------------------
//  channel   | handshake               | word
//  ----------+-------------------------+-------------------------------
//  command   | start high, busy low    | command (cmd, draw, read cell)
//  result    | result_valid, one cycle | result (status, cells, open)
//  config    | cfg_we                  | cfg_index, cfg_wdata
//
//  A carve step probes the four neighbors in S_SCAN on the map read port,
//  then writes the wall (S_WALL) and the target cell (S_CELL). Backtrack
//  goes through S_POP, a read through S_READ. Start clears the map one cell
//  a cycle, all 2^(2*clog2(MAX_DIM)) cells, and opens cell 0 as it goes.
//  After reset a clearing pass runs with busy high, leaving cell 0 a wall.
//  Results are shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module dfs_maze_carver #(
	parameter int MAX_DIM = dmc_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  dmc_pkg::in_t                      command,
	output logic                              busy,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [dmc_pkg::GRID_REG_W-1:0]    cfg_wdata,
	output logic                              result_valid,
	output dmc_pkg::out_t                     result
);

	localparam int CW        = $clog2(MAX_DIM);
	localparam int EW        = CW + 1;
	localparam int MAP_AW    = 2 * CW;
	localparam int MAP_DEPTH = 1 << MAP_AW;
	localparam int STK_DEPTH = ((MAX_DIM + 1) / 2) * ((MAX_DIM + 1) / 2);
	localparam int STK_AW    = $clog2(STK_DEPTH);
	localparam int STK_CW    = $clog2(STK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_WALL,
		S_CELL,
		S_POP,
		S_READ
	} state_t;

	state_t                            state_q;
	logic [dmc_pkg::GRID_REG_W-1:0]    grid_w_q;
	logic [dmc_pkg::GRID_REG_W-1:0]    grid_h_q;
	logic [MAP_AW-1:0]                 clr_addr_q;
	logic                              open0_q;
	logic [CW-1:0]                     cur_col_q;
	logic [CW-1:0]                     cur_row_q;
	logic [STK_CW-1:0]                 stk_cnt_q;
	logic [1:0]                        draw_q;
	logic [2:0]                        dir_q;
	logic [2:0]                        n_q;
	logic                              hit_q;
	logic [CW-1:0]                     sel_tgt_col_q;
	logic [CW-1:0]                     sel_tgt_row_q;
	logic [CW-1:0]                     sel_wall_col_q;
	logic [CW-1:0]                     sel_wall_row_q;
	logic                              rd_in_range_q;
	logic                              issued_s1;
	logic                              last_s1;
	logic                              inb_s1;
	logic [CW-1:0]                     tgt_col_s1;
	logic [CW-1:0]                     tgt_row_s1;
	logic [CW-1:0]                     wall_col_s1;
	logic [CW-1:0]                     wall_row_s1;
	logic                              result_valid_q;
	dmc_pkg::out_t                     result_q;

	logic [8:0]          gw9;
	logic [8:0]          gh9;
	logic [EW-1:0]       dim_w;
	logic [EW-1:0]       dim_h;
	logic [CW-1:0]       nb_tgt_col;
	logic [CW-1:0]       nb_tgt_row;
	logic [CW-1:0]       nb_wall_col;
	logic [CW-1:0]       nb_wall_row;
	logic                nb_inb;
	logic                map_we;
	logic [MAP_AW-1:0]   map_waddr;
	logic                map_wdata;
	logic [MAP_AW-1:0]   map_raddr;
	logic                map_rdata;
	logic                stk_we;
	logic [2*CW-1:0]     stk_rdata;
	logic                accept;
	logic                cand;
	logic                take;
	logic [2:0]          n_nx;
	logic                hit_nx;
	logic                rd_in_range;

	assign busy         = (state_q != S_IDLE);
	assign accept       = start && !busy;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Register values outside 1..MAX_DIM are clamped into range.
	always_comb begin
		gw9 = 9'(grid_w_q);
		gh9 = 9'(grid_h_q);
		if (grid_w_q == '0) begin
			dim_w = EW'(1);
		end else if (gw9 > 9'(MAX_DIM)) begin
			dim_w = EW'(MAX_DIM);
		end else begin
			dim_w = EW'(grid_w_q);
		end
		if (grid_h_q == '0) begin
			dim_h = EW'(1);
		end else if (gh9 > 9'(MAX_DIM)) begin
			dim_h = EW'(MAX_DIM);
		end else begin
			dim_h = EW'(grid_h_q);
		end
	end

	dmc_nbr #(
		.CW (CW)
	) u_nbr (
		.cur_col  (cur_col_q),
		.cur_row  (cur_row_q),
		.dir      (dmc_pkg::dir_t'(dir_q[1:0])),
		.dim_w    (dim_w),
		.dim_h    (dim_h),
		.tgt_col  (nb_tgt_col),
		.tgt_row  (nb_tgt_row),
		.wall_col (nb_wall_col),
		.wall_row (nb_wall_row),
		.inb      (nb_inb)
	);

	assign rd_in_range = (9'(command.read_col) < 9'(MAX_DIM)) &&
	                     (9'(command.read_row) < 9'(MAX_DIM));

	// Map port selection. In idle the read port serves the read command.
	always_comb begin
		map_we    = 1'b0;
		map_waddr = clr_addr_q;
		map_wdata = 1'b0;
		case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_addr_q;
				map_wdata = open0_q && (clr_addr_q == '0);
			end
			S_WALL: begin
				map_we    = 1'b1;
				map_waddr = {sel_wall_row_q, sel_wall_col_q};
				map_wdata = 1'b1;
			end
			S_CELL: begin
				map_we    = 1'b1;
				map_waddr = {sel_tgt_row_q, sel_tgt_col_q};
				map_wdata = 1'b1;
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
		if (state_q == S_IDLE) begin
			map_raddr = {CW'(command.read_row), CW'(command.read_col)};
		end else begin
			map_raddr = {nb_tgt_row, nb_tgt_col};
		end
	end

	dmc_ram #(
		.DEPTH (MAP_DEPTH),
		.WIDTH (1)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	assign stk_we = (state_q == S_WALL) && (stk_cnt_q < STK_CW'(STK_DEPTH));

	// The stack read port always looks at the top entry.
	dmc_ram #(
		.DEPTH (STK_DEPTH),
		.WIDTH (2 * CW)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (STK_AW'(stk_cnt_q)),
		.wdata ({cur_col_q, cur_row_q}),
		.raddr (STK_AW'(stk_cnt_q - STK_CW'(1))),
		.rdata (stk_rdata)
	);

	// A probe whose target is on the grid and still a wall is a candidate.
	always_comb begin
		cand   = issued_s1 && inb_s1 && !map_rdata;
		take   = cand && (n_q == {1'b0, draw_q});
		n_nx   = n_q + {2'b00, cand};
		hit_nx = hit_q || take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= dmc_pkg::GRID_REG_W'(dmc_pkg::DIM_RESET);
			grid_h_q <= dmc_pkg::GRID_REG_W'(dmc_pkg::DIM_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				dmc_pkg::REG_GRID_WIDTH:  grid_w_q <= cfg_wdata;
				dmc_pkg::REG_GRID_HEIGHT: grid_h_q <= cfg_wdata;
				default: begin
					grid_w_q <= grid_w_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_addr_q     <= '0;
			open0_q        <= 1'b0;
			cur_col_q      <= '0;
			cur_row_q      <= '0;
			stk_cnt_q      <= '0;
			dir_q          <= '0;
			n_q            <= '0;
			hit_q          <= 1'b0;
			issued_s1      <= 1'b0;
			last_s1        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (command.cmd)
							dmc_pkg::CMD_START: begin
								clr_addr_q <= '0;
								open0_q    <= 1'b1;
								stk_cnt_q  <= '0;
								cur_col_q  <= '0;
								cur_row_q  <= '0;
								state_q    <= S_CLEAR;
							end
							dmc_pkg::CMD_STEP: begin
								draw_q    <= command.random_draw;
								dir_q     <= '0;
								n_q       <= '0;
								hit_q     <= 1'b0;
								issued_s1 <= 1'b0;
								state_q   <= S_SCAN;
							end
							dmc_pkg::CMD_READ: begin
								rd_in_range_q <= rd_in_range;
								state_q       <= S_READ;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + MAP_AW'(1);
					if (clr_addr_q == '1) begin
						state_q <= S_IDLE;
						if (open0_q) begin
							result_valid_q <= 1'b1;
							result_q       <= '{status: dmc_pkg::ST_STARTED, cell_col: '0,
							                    cell_row: '0, wall_col: '0, wall_row: '0,
							                    cell_open: 1'b0};
						end
					end
				end
				S_SCAN: begin
					// Issue the next probe while the previous one is evaluated.
					if (dir_q != 3'd4) begin
						issued_s1   <= 1'b1;
						last_s1     <= (dir_q == 3'd3);
						inb_s1      <= nb_inb;
						tgt_col_s1  <= nb_tgt_col;
						tgt_row_s1  <= nb_tgt_row;
						wall_col_s1 <= nb_wall_col;
						wall_row_s1 <= nb_wall_row;
						dir_q       <= dir_q + 3'd1;
					end else begin
						issued_s1 <= 1'b0;
					end
					if (issued_s1) begin
						n_q   <= n_nx;
						hit_q <= hit_nx;
						if (take) begin
							sel_tgt_col_q  <= tgt_col_s1;
							sel_tgt_row_q  <= tgt_row_s1;
							sel_wall_col_q <= wall_col_s1;
							sel_wall_row_q <= wall_row_s1;
						end
						if (last_s1) begin
							if (n_nx == 3'd0) begin
								if (stk_cnt_q != '0) begin
									stk_cnt_q <= stk_cnt_q - STK_CW'(1);
									state_q   <= S_POP;
								end else begin
									state_q        <= S_IDLE;
									result_valid_q <= 1'b1;
									result_q       <= '{status: dmc_pkg::ST_DONE,
									                    cell_col: '0, cell_row: '0,
									                    wall_col: '0, wall_row: '0,
									                    cell_open: 1'b0};
								end
							end else if (!hit_nx) begin
								state_q        <= S_IDLE;
								result_valid_q <= 1'b1;
								result_q       <= '{status: dmc_pkg::ST_RETRY,
								                    cell_col: dmc_pkg::COORD_W'(cur_col_q),
								                    cell_row: dmc_pkg::COORD_W'(cur_row_q),
								                    wall_col: '0, wall_row: '0,
								                    cell_open: 1'b0};
							end else begin
								state_q <= S_WALL;
							end
						end
					end
				end
				S_WALL: begin
					if (stk_we) begin
						stk_cnt_q <= stk_cnt_q + STK_CW'(1);
					end
					state_q <= S_CELL;
				end
				S_CELL: begin
					cur_col_q      <= sel_tgt_col_q;
					cur_row_q      <= sel_tgt_row_q;
					state_q        <= S_IDLE;
					result_valid_q <= 1'b1;
					result_q       <= '{status: dmc_pkg::ST_CARVED,
					                    cell_col: dmc_pkg::COORD_W'(sel_tgt_col_q),
					                    cell_row: dmc_pkg::COORD_W'(sel_tgt_row_q),
					                    wall_col: dmc_pkg::COORD_W'(sel_wall_col_q),
					                    wall_row: dmc_pkg::COORD_W'(sel_wall_row_q),
					                    cell_open: 1'b0};
				end
				S_POP: begin
					cur_col_q      <= stk_rdata[2*CW-1:CW];
					cur_row_q      <= stk_rdata[CW-1:0];
					state_q        <= S_IDLE;
					result_valid_q <= 1'b1;
					result_q       <= '{status: dmc_pkg::ST_BACKTRACKED,
					                    cell_col: dmc_pkg::COORD_W'(stk_rdata[2*CW-1:CW]),
					                    cell_row: dmc_pkg::COORD_W'(stk_rdata[CW-1:0]),
					                    wall_col: '0, wall_row: '0, cell_open: 1'b0};
				end
				S_READ: begin
					state_q        <= S_IDLE;
					result_valid_q <= 1'b1;
					result_q       <= '{status: dmc_pkg::ST_READ, cell_col: '0,
					                    cell_row: '0, wall_col: '0, wall_row: '0,
					                    cell_open: map_rdata && rd_in_range_q};
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/dmc_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_chk: port checker for the maze carver
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module dmc_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input dmc_pkg::in_t                      command,
	input logic                              busy,
	input logic                              result_valid,
	input dmc_pkg::out_t                     result
);

	// A result word only ever closes a stretch of work.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result word without preceding work");

	// Every real command makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command.cmd == dmc_pkg::CMD_START ||
		 command.cmd == dmc_pkg::CMD_STEP || command.cmd == dmc_pkg::CMD_READ))
		|=> busy)
		else $error("accepted command did not make the block busy");

	// One word per item, and result words never come on back-to-back cycles.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result words on back-to-back cycles");

	// Only a read reports an open cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != dmc_pkg::ST_READ) |-> !result.cell_open)
		else $error("cell_open set outside a read result");

endmodule

bind dfs_maze_carver dmc_chk u_dmc_chk (.*);
